@@ rtl/core/sdg_pkg.sv @@
// ----------------------------------------------------------------------------
// sdg_pkg: shared types, constants and helper functions
// Holds the sample widths, the register and law codes, the data carried from
// one square-root cell to the next, and the root table for the dB conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package sdg_pkg;

	// Sample width and derived widths.
	localparam int SAMPLE_BITS = 24;
	localparam int SB          = SAMPLE_BITS;
	localparam int WIDE        = 2 * SB + 24;
	localparam int PROD_W      = SB + 34;
	localparam int DB_W        = 13;
	localparam int GAIN_W      = 32;
	localparam int CFG_W       = SB;
	localparam int IDX_W       = 3;

	typedef logic signed [SB-1:0]   smp_t;
	typedef logic signed [WIDE-1:0] wide_t;
	typedef logic signed [DB_W-1:0] db_t;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_MASTER_DB = 3'd0;
	localparam logic [IDX_W-1:0] REG_LEFT_DB   = 3'd1;
	localparam logic [IDX_W-1:0] REG_RIGHT_DB  = 3'd2;
	localparam logic [IDX_W-1:0] REG_MONO_LAW  = 3'd3;
	localparam logic [IDX_W-1:0] REG_DC_OFFSET = 3'd4;

	// Channel pick codes.
	localparam logic [1:0] PICK_LEFT  = 2'd1;
	localparam logic [1:0] PICK_RIGHT = 2'd2;

	// Downmix laws; the unused code falls back to the average.
	typedef enum logic [2:0] {
		LAW_AVG,
		LAW_RMS,
		LAW_SUM,
		LAW_SUM_ATT,
		LAW_MAXMAG,
		LAW_LEFT,
		LAW_RIGHT
	} law_t;

	// Gain converter states.
	typedef enum logic [1:0] {
		GC_IDLE,
		GC_LOG,
		GC_ITER,
		GC_ROUND
	} gc_state_t;

	// dB conversion constants.
	localparam logic signed [DB_W-1:0] DB_MAX   = 13'sd384;
	localparam logic signed [DB_W-1:0] DB_FLOOR = -13'sd2240;
	localparam logic signed [41:0] LOG2_STEP_Q32 = 42'sd44586164;
	localparam logic signed [41:0] U_OFFSET      = 42'sd137438953472;
	localparam int ROOT_STEPS = 20;
	localparam logic [GAIN_W-1:0] UNITY_Q16 = 32'd65536;
	localparam logic [GAIN_W-1:0] M_INIT    = 32'd1073741824;

	// Downmix constants.
	localparam logic signed [30:0] INV_SQRT2_Q30 = 31'sd759250125;
	localparam wide_t RND16 = wide_t'(64'sd32768);
	localparam wide_t RND30 = wide_t'(64'sd536870912);
	localparam wide_t SMP_MAX = wide_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam wide_t SMP_MIN = -SMP_MAX - wide_t'(64'sd1);

	// Status of the gain converter seen by the sample path.
	typedef struct packed {
		logic              busy;
		logic [GAIN_W-1:0] left;
		logic [GAIN_W-1:0] right;
	} gain_t;

	// Square-root working set handed from cell to cell.
	typedef struct packed {
		logic [2*SB-1:0] rad;
		logic [SB+1:0]   rem;
		logic [SB-1:0]   root;
	} sqrt_t;

	// Sample results that travel alongside the square root.
	typedef struct packed {
		smp_t       l;
		smp_t       r;
		smp_t       mix;
		logic       neg;
		logic [1:0] pick;
	} meta_t;

	typedef logic [ROOT_STEPS:0][GAIN_W-1:0] root_tab_t;

	// Saturate a wide signed value to the sample range.
	function automatic smp_t sat(input wide_t x);
		wide_t y;
		begin
			y = x;
			if (x > SMP_MAX) begin
				y = SMP_MAX;
			end else if (x < SMP_MIN) begin
				y = SMP_MIN;
			end
			return y[SB-1:0];
		end
	endfunction

	// Integer square root, used only to build the constant root table.
	function automatic logic [63:0] isqrt_c(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] v;
		begin
			r = '0;
			b = 64'd1 << 62;
			v = x;
			for (int j = 0; j < 32; j++) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		end
	endfunction

	// Successive square roots of two in Q30, starting from two itself.
	function automatic root_tab_t gen_roots();
		root_tab_t   t;
		logic [63:0] s;
		begin
			s = 64'd1 << 31;
			t[0] = s[GAIN_W-1:0];
			for (int i = 1; i <= ROOT_STEPS; i++) begin
				s = isqrt_c(s << 30);
				t[i] = s[GAIN_W-1:0];
			end
			return t;
		end
	endfunction

	localparam root_tab_t ROOT_TAB = gen_roots();

endpackage

`default_nettype wire

@@ rtl/core/sdg_gain_conv.sv @@
// ----------------------------------------------------------------------------
// sdg_gain_conv: dB to linear gain converter
// Turns the master and side dB settings into Q8.16 linear gains, one side
// after the other, with one mantissa multiply per fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module sdg_gain_conv (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire sdg_pkg::db_t  master_db,
	input  wire sdg_pkg::db_t  left_db,
	input  wire sdg_pkg::db_t  right_db,
	output sdg_pkg::gain_t     stat
);

	sdg_pkg::gc_state_t state_q;
	sdg_pkg::gc_state_t state_n;
	logic                        side_q;
	logic signed [41:0]          u_q;
	logic                        zero_q;
	logic [sdg_pkg::GAIN_W-1:0]  m_q;
	logic [4:0]                  it_q;
	logic [sdg_pkg::GAIN_W-1:0]  left_gain_q;
	logic [sdg_pkg::GAIN_W-1:0]  right_gain_q;

	sdg_pkg::db_t         mdb_c;
	sdg_pkg::db_t         sdb_c;
	sdg_pkg::db_t         side_db;
	logic signed [13:0]   d_c;
	logic signed [41:0]   u_n;
	logic                 floor_hit;
	logic [63:0]          mprod;
	logic [5:0]           bit_idx;
	logic [5:0]           n_c;
	logic [5:0]           k_c;
	logic [47:0]          acc;
	logic [47:0]          shifted;
	logic [sdg_pkg::GAIN_W-1:0] gain_n;

	// Clamp the settings and form log2 of the gain in Q32.
	always_comb begin
		side_db   = side_q ? right_db : left_db;
		mdb_c     = (master_db > sdg_pkg::DB_MAX) ? sdg_pkg::DB_MAX : master_db;
		sdb_c     = (side_db > sdg_pkg::DB_MAX) ? sdg_pkg::DB_MAX : side_db;
		floor_hit = (mdb_c <= sdg_pkg::DB_FLOOR) || (sdb_c <= sdg_pkg::DB_FLOOR);
		d_c       = 14'(mdb_c) + 14'(sdb_c);
		u_n       = 42'(d_c) * sdg_pkg::LOG2_STEP_Q32 + sdg_pkg::U_OFFSET;
	end

	// One fraction bit per step: multiply by the matching root of two.
	always_comb begin
		mprod   = 64'(m_q) * 64'(sdg_pkg::ROOT_TAB[it_q]);
		bit_idx = 6'd32 - {1'b0, it_q};
	end

	// Scale the mantissa by the integer part with rounding.
	always_comb begin
		n_c     = u_q[37:32];
		k_c     = 6'd46 - n_c;
		acc     = {16'b0, m_q} + (48'd1 << (k_c - 6'd1));
		shifted = acc >> k_c;
		gain_n  = (zero_q || u_q[41]) ? '0 : shifted[sdg_pkg::GAIN_W-1:0];
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			sdg_pkg::GC_IDLE:  state_n = sdg_pkg::GC_IDLE;
			sdg_pkg::GC_LOG:   state_n = sdg_pkg::GC_ITER;
			sdg_pkg::GC_ITER: begin
				if (it_q == 5'(sdg_pkg::ROOT_STEPS)) begin
					state_n = sdg_pkg::GC_ROUND;
				end
			end
			sdg_pkg::GC_ROUND: state_n = side_q ? sdg_pkg::GC_IDLE : sdg_pkg::GC_LOG;
			default:           state_n = sdg_pkg::GC_IDLE;
		endcase
		if (start) begin
			state_n = sdg_pkg::GC_LOG;
		end
	end

	// Outputs.
	always_comb begin
		stat.busy  = start || (state_q != sdg_pkg::GC_IDLE);
		stat.left  = left_gain_q;
		stat.right = right_gain_q;
	end

	// State and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sdg_pkg::GC_IDLE;
			side_q       <= 1'b0;
			left_gain_q  <= sdg_pkg::UNITY_Q16;
			right_gain_q <= sdg_pkg::UNITY_Q16;
		end else begin
			state_q <= state_n;
			if (start) begin
				side_q <= 1'b0;
			end else if (state_q == sdg_pkg::GC_ROUND) begin
				side_q <= 1'b1;
				if (side_q) begin
					right_gain_q <= gain_n;
				end else begin
					left_gain_q <= gain_n;
				end
			end
		end
	end

	// Working registers of the conversion.
	always_ff @(posedge clk) begin
		case (state_q)
			sdg_pkg::GC_LOG: begin
				u_q    <= u_n;
				zero_q <= floor_hit;
				m_q    <= sdg_pkg::M_INIT;
				it_q   <= 5'd1;
			end
			sdg_pkg::GC_ITER: begin
				if (u_q[bit_idx]) begin
					m_q <= mprod[61:30];
				end
				it_q <= it_q + 5'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/sdg_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// sdg_sqrt_cell: one bit of the pipelined square root
// Brings in the next two radicand bits, settles one root bit and hands the
// working set and the sample results to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sdg_sqrt_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           valid_i,
	input  wire sdg_pkg::sqrt_t sq_i,
	input  wire sdg_pkg::meta_t meta_i,
	output logic                valid_o,
	output sdg_pkg::sqrt_t      sq_o,
	output sdg_pkg::meta_t      meta_o
);

	localparam int SB = sdg_pkg::SB;

	logic [SB+3:0]  rem_sh;
	logic [SB+3:0]  trial;
	logic [SB+3:0]  diff;
	sdg_pkg::sqrt_t sq_n;

	// Restoring step: keep the trial bit when the remainder allows it.
	always_comb begin
		rem_sh = {sq_i.rem, sq_i.rad[2*SB-1:2*SB-2]};
		trial  = {2'b00, sq_i.root, 2'b01};
		diff   = rem_sh - trial;
		sq_n.rad = {sq_i.rad[2*SB-3:0], 2'b00};
		if (rem_sh >= trial) begin
			sq_n.rem  = diff[SB+1:0];
			sq_n.root = {sq_i.root[SB-2:0], 1'b1};
		end else begin
			sq_n.rem  = rem_sh[SB+1:0];
			sq_n.root = {sq_i.root[SB-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_o   <= sq_n;
			meta_o <= meta_i;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/stereo_db_gain_with_mono_sum.sv @@
// ----------------------------------------------------------------------------
// stereo_db_gain_with_mono_sum: stereo gain stage with mono downmix
// Pipeline: from input transfer to result valid, a sample passes through
// five arithmetic stages, one square-root cell per root bit, one output stage.
// Throughput: one sample per cycle unless the output stalls; a dB register write
// holds off input while the two gains are reconverted, one multiply per step.
// Reset clears the valid bits and settings to zero and both gains to unity.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_db_gain_with_mono_sum (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sdg_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [sdg_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [sdg_pkg::SB-1:0] mono_in,
	input  wire logic signed [sdg_pkg::SB-1:0] left_in,
	input  wire logic signed [sdg_pkg::SB-1:0] right_in,
	input  wire logic [1:0]                    channel_pick,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [sdg_pkg::SB-1:0]      out_left,
	output logic signed [sdg_pkg::SB-1:0]      out_right,
	output logic signed [sdg_pkg::SB-1:0]      out_mono,
	output logic signed [sdg_pkg::SB-1:0]      picked
);

	localparam int SB = sdg_pkg::SB;

	// Configuration registers.
	sdg_pkg::db_t  master_db_q;
	sdg_pkg::db_t  left_db_q;
	sdg_pkg::db_t  right_db_q;
	sdg_pkg::law_t mono_law_q;
	sdg_pkg::smp_t dc_offset_q;
	logic          start_q;
	sdg_pkg::gain_t gstat;

	logic en;
	logic accept;

	// Pipeline registers.
	logic                        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic signed [SB:0]          sum_l_s1, sum_r_s1;
	logic [1:0]                  pick_s1, pick_s2, pick_s3, pick_s4;
	logic signed [sdg_pkg::PROD_W-1:0] p_l_s2, p_r_s2;
	sdg_pkg::smp_t               l_s3, r_s3, l_s4, r_s4;
	logic signed [2*SB-1:0]      sql_s4, sqr_s4;
	logic signed [SB:0]          lr_s4;
	logic signed [SB+31:0]       att_s4;
	sdg_pkg::sqrt_t              sq_s5;
	sdg_pkg::meta_t              meta_s5;

	logic                        out_valid_q;
	sdg_pkg::smp_t               out_left_q, out_right_q, out_mono_q, picked_q;

	// Configuration writes; dB writes restart the gain conversion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_db_q <= '0;
			left_db_q   <= '0;
			right_db_q  <= '0;
			mono_law_q  <= sdg_pkg::LAW_AVG;
			dc_offset_q <= '0;
			start_q     <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					sdg_pkg::REG_MASTER_DB: begin
						master_db_q <= cfg_data[sdg_pkg::DB_W-1:0];
						start_q     <= 1'b1;
					end
					sdg_pkg::REG_LEFT_DB: begin
						left_db_q <= cfg_data[sdg_pkg::DB_W-1:0];
						start_q   <= 1'b1;
					end
					sdg_pkg::REG_RIGHT_DB: begin
						right_db_q <= cfg_data[sdg_pkg::DB_W-1:0];
						start_q    <= 1'b1;
					end
					sdg_pkg::REG_MONO_LAW: mono_law_q  <= sdg_pkg::law_t'(cfg_data[2:0]);
					sdg_pkg::REG_DC_OFFSET: dc_offset_q <= cfg_data[SB-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	sdg_gain_conv u_gain_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.master_db (master_db_q),
		.left_db   (left_db_q),
		.right_db  (right_db_q),
		.stat      (gstat)
	);

	// The whole pipeline advances whenever the output stage can take data.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en && !gstat.busy && !cfg_we;
	assign accept   = in_valid && in_ready;

	// Stage 1: add the mono sample to each side.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_l_s1 <= {left_in[SB-1], left_in} + {mono_in[SB-1], mono_in};
			sum_r_s1 <= {right_in[SB-1], right_in} + {mono_in[SB-1], mono_in};
			pick_s1  <= channel_pick;
		end
	end

	// Stage 2: apply the linear gains.
	always_ff @(posedge clk) begin
		if (en) begin
			p_l_s2  <= sum_l_s1 * $signed({1'b0, gstat.left});
			p_r_s2  <= sum_r_s1 * $signed({1'b0, gstat.right});
			pick_s2 <= pick_s1;
		end
	end

	// Stage 3: round, add the offset and saturate.
	always_ff @(posedge clk) begin
		if (en) begin
			l_s3 <= sdg_pkg::sat(((sdg_pkg::wide_t'(p_l_s2) + sdg_pkg::RND16) >>> 16)
				+ sdg_pkg::wide_t'(dc_offset_q));
			r_s3 <= sdg_pkg::sat(((sdg_pkg::wide_t'(p_r_s2) + sdg_pkg::RND16) >>> 16)
				+ sdg_pkg::wide_t'(dc_offset_q));
			pick_s3 <= pick_s2;
		end
	end

	// Stage 4: squares for the RMS law and the attenuated sum product.
	logic signed [SB:0] lr_c;
	assign lr_c = {l_s3[SB-1], l_s3} + {r_s3[SB-1], r_s3};

	always_ff @(posedge clk) begin
		if (en) begin
			l_s4    <= l_s3;
			r_s4    <= r_s3;
			sql_s4  <= l_s3 * l_s3;
			sqr_s4  <= r_s3 * r_s3;
			lr_s4   <= lr_c;
			att_s4  <= lr_c * sdg_pkg::INV_SQRT2_Q30;
			pick_s4 <= pick_s3;
		end
	end

	// Stage 5: halve the sum of squares and form the other downmix laws.
	logic [2*SB:0]      sq_sum;
	logic signed [SB:0] al_c, ar_c;
	sdg_pkg::smp_t      mix_c;

	always_comb begin
		sq_sum = {1'b0, sql_s4} + {1'b0, sqr_s4};
		al_c   = l_s4[SB-1] ? -{l_s4[SB-1], l_s4} : {l_s4[SB-1], l_s4};
		ar_c   = r_s4[SB-1] ? -{r_s4[SB-1], r_s4} : {r_s4[SB-1], r_s4};
		case (mono_law_q)
			sdg_pkg::LAW_SUM:     mix_c = sdg_pkg::sat(sdg_pkg::wide_t'(lr_s4));
			sdg_pkg::LAW_SUM_ATT: mix_c = sdg_pkg::sat((sdg_pkg::wide_t'(att_s4)
				+ sdg_pkg::RND30) >>> 30);
			sdg_pkg::LAW_MAXMAG:  mix_c = (al_c >= ar_c) ? l_s4 : r_s4;
			sdg_pkg::LAW_LEFT:    mix_c = l_s4;
			sdg_pkg::LAW_RIGHT:   mix_c = r_s4;
			default:              mix_c = lr_s4[SB:1];
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s5.rad    <= sq_sum[2*SB:1];
			sq_s5.rem    <= '0;
			sq_s5.root   <= '0;
			meta_s5.l    <= l_s4;
			meta_s5.r    <= r_s4;
			meta_s5.mix  <= mix_c;
			meta_s5.neg  <= lr_s4[SB];
			meta_s5.pick <= pick_s4;
		end
	end

	// Valid bits of the arithmetic stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Row of square-root cells, one root bit each.
	logic           valid_c [0:SB];
	sdg_pkg::sqrt_t sq_c    [0:SB];
	sdg_pkg::meta_t meta_c  [0:SB];

	assign valid_c[0] = valid_s5;
	assign sq_c[0]    = sq_s5;
	assign meta_c[0]  = meta_s5;

	for (genvar g = 0; g < SB; g++) begin : g_cell
		sdg_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (valid_c[g]),
			.sq_i    (sq_c[g]),
			.meta_i  (meta_c[g]),
			.valid_o (valid_c[g+1]),
			.sq_o    (sq_c[g+1]),
			.meta_o  (meta_c[g+1])
		);
	end

	// Output stage: sign the RMS value and pick the requested channel.
	sdg_pkg::wide_t root_w;
	sdg_pkg::smp_t  mono_c;
	sdg_pkg::smp_t  pick_c;
	sdg_pkg::meta_t meta_e;

	always_comb begin
		meta_e = meta_c[SB];
		root_w = sdg_pkg::wide_t'({1'b0, sq_c[SB].root});
		if (mono_law_q == sdg_pkg::LAW_RMS) begin
			mono_c = sdg_pkg::sat(meta_e.neg ? -root_w : root_w);
		end else begin
			mono_c = meta_e.mix;
		end
		case (meta_e.pick)
			sdg_pkg::PICK_LEFT:  pick_c = meta_e.l;
			sdg_pkg::PICK_RIGHT: pick_c = meta_e.r;
			default:             pick_c = mono_c;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_c[SB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_left_q  <= meta_e.l;
			out_right_q <= meta_e.r;
			out_mono_q  <= mono_c;
			picked_q    <= pick_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_left  = out_left_q;
	assign out_right = out_right_q;
	assign out_mono  = out_mono_q;
	assign picked    = picked_q;

`ifndef SYNTHESIS
	// No sample may enter while the gains are being reconverted.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		gstat.busy |-> !in_ready)
		else $error("input transfer while gain conversion busy");

	// A dB write must start the converter on the next cycle.
	a_cfg_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_index == sdg_pkg::REG_MASTER_DB
			|| cfg_index == sdg_pkg::REG_LEFT_DB
			|| cfg_index == sdg_pkg::REG_RIGHT_DB)) |=> gstat.busy)
		else $error("dB write did not start gain conversion");

	// A stalled result stays in the output stage.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_mono_q)))
		else $error("output stage lost a stalled result");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the stereo gain stage with mono downmix
// Writes several gain, downmix-law and offset settings, pushes directed and
// random sample triples through the valid/ready channels with random gaps,
// and compares every result transfer with a bit-exact predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 200;

	typedef struct {
		sdg_pkg::smp_t mono;
		sdg_pkg::smp_t left;
		sdg_pkg::smp_t right;
		logic [1:0]    pick;
	} sample_t;

	typedef struct {
		sdg_pkg::smp_t l;
		sdg_pkg::smp_t r;
		sdg_pkg::smp_t m;
		sdg_pkg::smp_t p;
	} mix_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [sdg_pkg::IDX_W-1:0] cfg_index;
	logic [sdg_pkg::CFG_W-1:0] cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	sdg_pkg::smp_t             mono_in;
	sdg_pkg::smp_t             left_in;
	sdg_pkg::smp_t             right_in;
	logic [1:0]                channel_pick;
	logic                      out_valid;
	logic                      out_ready;
	sdg_pkg::smp_t             out_left;
	sdg_pkg::smp_t             out_right;
	sdg_pkg::smp_t             out_mono;
	sdg_pkg::smp_t             picked;

	// Predictor copy of the registers and the converted gains.
	longint          master_q, left_q, right_q, offset_q;
	logic [2:0]      law_q;
	longint unsigned left_lin, right_lin;

	sample_t samples_pending[$];
	mix_t    mix_expected[$];
	bit      in_taken;
	int      sent_count, rx_count, err_count, mism_count, quiet_cycles;
	int      hold_left;
	bit      hold_done;

	stereo_db_gain_with_mono_sum u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.mono_in(mono_in), .left_in(left_in), .right_in(right_in),
		.channel_pick(channel_pick), .out_valid(out_valid), .out_ready(out_ready),
		.out_left(out_left), .out_right(out_right), .out_mono(out_mono),
		.picked(picked)
	);

	always #2 clk = ~clk;

	// Bit-serial integer square root.
	function automatic longint unsigned root64(input longint unsigned x);
		longint unsigned r, b, v;
		begin
			r = 0;
			b = 64'd1 << 62;
			v = x;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		end
	endfunction

	// dB pair to unsigned Q8.16 linear gain, via log2 and successive roots.
	function automatic longint unsigned db_to_linear(input longint mdb, input longint sdb);
		longint          d, u;
		longint unsigned f, m, s;
		int              n, k;
		begin
			if (mdb > 384) mdb = 384;
			if (sdb > 384) sdb = 384;
			if (mdb <= -2240 || sdb <= -2240) return 0;
			d = mdb + sdb;
			u = d * 64'sd44586164 + (64'sd32 <<< 32);
			if (u < 0) return 0;
			n = int'(u >>> 32);
			f = u & 64'hFFFF_FFFF;
			m = 64'd1 << 30;
			s = 64'd1 << 31;
			for (int i = 1; i <= 20; i++) begin
				s = root64(s << 30);
				if ((f >> (32 - i)) & 1) m = (m * s) >> 30;
			end
			k = 46 - n;
			return ((m + (64'd1 << (k - 1))) >> k) & 64'hFFFF_FFFF;
		end
	endfunction

	function automatic longint clip24(input longint x);
		if (x > 8388607) return 8388607;
		if (x < -8388608) return -8388608;
		return x;
	endfunction

	function automatic longint scale_side(input longint x, input longint mono,
			input longint unsigned g);
		longint p;
		begin
			p = (x + mono) * longint'(g);
			return clip24(((p + 32768) >>> 16) + offset_q);
		end
	endfunction

	function automatic longint mix_down(input longint l, input longint r);
		longint al, ar, mag;
		begin
			al = l < 0 ? -l : l;
			ar = r < 0 ? -r : r;
			case (law_q)
				sdg_pkg::LAW_RMS: begin
					mag = longint'(root64(longint'(al * al + ar * ar) >> 1));
					return clip24((l + r) < 0 ? -mag : mag);
				end
				sdg_pkg::LAW_SUM:     return clip24(l + r);
				sdg_pkg::LAW_SUM_ATT: return clip24(((l + r) * 64'sd759250125
					+ (64'sd1 <<< 29)) >>> 30);
				sdg_pkg::LAW_MAXMAG:  return al >= ar ? l : r;
				sdg_pkg::LAW_LEFT:    return l;
				sdg_pkg::LAW_RIGHT:   return r;
				default:              return (l + r) >>> 1;
			endcase
		end
	endfunction

	function automatic mix_t predict_mix(input sample_t s);
		mix_t   e;
		longint l, r, m;
		begin
			l = scale_side(longint'(s.left), longint'(s.mono), left_lin);
			r = scale_side(longint'(s.right), longint'(s.mono), right_lin);
			m = mix_down(l, r);
			e.l = sdg_pkg::smp_t'(l);
			e.r = sdg_pkg::smp_t'(r);
			e.m = sdg_pkg::smp_t'(m);
			e.p = s.pick == sdg_pkg::PICK_LEFT ? e.l
				: (s.pick == sdg_pkg::PICK_RIGHT ? e.r : e.m);
			return e;
		end
	endfunction

	// Input driver: presents the next pending sample, with random gaps except
	// during one long stretch of back-to-back transfers.
	always @(negedge clk) begin
		sample_t s;
		if (arst_n && !(in_valid && !in_taken)) begin
			if (samples_pending.size() != 0 &&
					((sent_count >= 150 && sent_count < 260) || $urandom_range(99) >= 37)) begin
				s = samples_pending.pop_front();
				mono_in <= s.mono;
				left_in <= s.left;
				right_in <= s.right;
				channel_pick <= s.pick;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output side: random stalls, one long hold-off so the pipeline backs up.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && rx_count >= 60) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= (rx_count >= 180 && rx_count < 280) ? 1'b1 : ($urandom_range(99) >= 37);
		end
	end

	// Transfer tracking, prediction and result checking at the rising edge.
	always @(posedge clk) begin
		mix_t   e;
		sample_t s;
		in_taken = in_valid && in_ready;
		if (in_taken) begin
			s.mono = mono_in;
			s.left = left_in;
			s.right = right_in;
			s.pick = channel_pick;
			mix_expected.push_back(predict_mix(s));
			sent_count++;
		end
		if (out_valid && out_ready) begin
			rx_count++;
			if (mix_expected.size() == 0) begin
				err_count++;
				$display("unexpected result transfer: %0d %0d %0d %0d",
					out_left, out_right, out_mono, picked);
			end else begin
				e = mix_expected.pop_front();
				if (e.l !== out_left || e.r !== out_right || e.m !== out_mono || e.p !== picked) begin
					err_count++;
					mism_count++;
					if (mism_count <= 10)
						$display("mismatch at result %0d: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
							rx_count, e.l, e.r, e.m, e.p, out_left, out_right, out_mono, picked);
				end
			end
		end
		if (in_taken || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
	end

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(input logic [sdg_pkg::IDX_W-1:0] idx, input longint value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[sdg_pkg::CFG_W-1:0];
		case (idx)
			sdg_pkg::REG_MASTER_DB:
				master_q = longint'(sdg_pkg::db_t'(value[sdg_pkg::DB_W-1:0]));
			sdg_pkg::REG_LEFT_DB:
				left_q = longint'(sdg_pkg::db_t'(value[sdg_pkg::DB_W-1:0]));
			sdg_pkg::REG_RIGHT_DB:
				right_q = longint'(sdg_pkg::db_t'(value[sdg_pkg::DB_W-1:0]));
			sdg_pkg::REG_MONO_LAW:
				law_q = value[2:0];
			sdg_pkg::REG_DC_OFFSET:
				offset_q = longint'(sdg_pkg::smp_t'(value[sdg_pkg::SB-1:0]));
			default: ;
		endcase
		left_lin = db_to_linear(master_q, left_q);
		right_lin = db_to_linear(master_q, right_q);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_sample(input longint mono, input longint l, input longint r,
			input int pick);
		sample_t s;
		s.mono = sdg_pkg::smp_t'(mono);
		s.left = sdg_pkg::smp_t'(l);
		s.right = sdg_pkg::smp_t'(r);
		s.pick = pick[1:0];
		samples_pending.push_back(s);
	endtask

	// Random sample: full range, or small values that survive large gains.
	task automatic queue_random(input int count);
		sdg_pkg::smp_t a, b, c;
		for (int i = 0; i < count; i++) begin
			a = sdg_pkg::smp_t'($urandom);
			b = sdg_pkg::smp_t'($urandom);
			c = sdg_pkg::smp_t'($urandom);
			if ($urandom_range(1) == 0) begin
				a = a >>> $urandom_range(22, 6);
				b = b >>> $urandom_range(22, 6);
				c = c >>> $urandom_range(22, 6);
			end
			queue_sample(a, b, c, $urandom_range(3));
		end
	endtask

	task automatic drain();
		while (samples_pending.size() != 0 || mix_expected.size() != 0 || in_valid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic setting(input longint m, input longint l, input longint r,
			input int law, input longint dc);
		write_reg(sdg_pkg::REG_MASTER_DB, m);
		write_reg(sdg_pkg::REG_LEFT_DB, l);
		write_reg(sdg_pkg::REG_RIGHT_DB, r);
		write_reg(sdg_pkg::REG_MONO_LAW, law);
		write_reg(sdg_pkg::REG_DC_OFFSET, dc);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		mono_in = '0;
		left_in = '0;
		right_in = '0;
		channel_pick = '0;
		master_q = 0; left_q = 0; right_q = 0; offset_q = 0; law_q = '0;
		left_lin = 65536; right_lin = 65536;
		in_taken = 1'b0;
		sent_count = 0; rx_count = 0; err_count = 0; mism_count = 0;
		quiet_cycles = 0; hold_left = 0; hold_done = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed samples at reset settings: field extremes and every pick.
		queue_sample(0, 0, 0, 0);
		queue_sample(8388607, 8388607, 8388607, 0);
		queue_sample(-8388608, -8388608, -8388608, 1);
		queue_sample(8388607, -8388608, 8388607, 2);
		queue_sample(-1, -1, -1, 3);
		queue_sample(0, 8388607, -8388608, 3);
		queue_sample(1, -1, 1, 1);
		queue_sample(-4194304, 4194304, -4194305, 2);
		queue_random(12);
		drain();

		// Every law, including the unused code, with gains across the range.
		for (int law = 0; law < 8; law++) begin
			setting($urandom_range(0, 600) - 400, $urandom_range(0, 600) - 400,
				$urandom_range(0, 600) - 400, law,
				longint'(sdg_pkg::smp_t'($urandom)) >>> 4);
			queue_sample(8388607, 8388607, -8388608, 0);
			queue_sample(-8388608, 100, -100, 3);
			queue_random(40);
			drain();
		end

		// Gain extremes: above +24 dB, the -140 dB floor, just above it.
		setting(4095, 384, -4096, sdg_pkg::LAW_RMS, 8388607);
		queue_random(25);
		drain();
		setting(-2240, 0, 0, sdg_pkg::LAW_SUM, -8388608);
		queue_random(15);
		drain();
		setting(-2239, -2239, 384, sdg_pkg::LAW_SUM_ATT, 0);
		queue_random(20);
		drain();
		setting(384, 384, 384, sdg_pkg::LAW_MAXMAG, -8388608);
		queue_random(25);
		drain();
		setting(0, -2241, 7, sdg_pkg::LAW_AVG, 1);
		queue_random(25);
		drain();

		if (err_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
